// ----- hw/rtl/assert_macros.svh -----
// assertion macros used by the checker file lkt_checker.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion with asynchronous active-low reset disable
`define ASSERT_CLK(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");

// condition that must never be seen outside reset
`define ASSERT_NEVER(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) not (prop)) \
		else $error("forbidden condition seen");

`endif

// ----- hw/rtl/lkt_pkg.sv -----
// types and constants for the lru keyed table
package lkt_pkg;

	localparam int CAPACITY   = 256;
	localparam int VALUE_BITS = 32;
	localparam int SLOT_W     = $clog2(CAPACITY);
	localparam int CNT_W      = $clog2(CAPACITY + 1);
	localparam int KEY_W      = 64 + 64 + 16;

	localparam logic [1:0] KIND_PUT = 2'd0;
	localparam logic [1:0] KIND_GET = 2'd1;
	localparam logic [1:0] KIND_DEL = 2'd2;

	typedef struct packed {
		logic [1:0]            kind;
		logic [63:0]           key_addr_high;
		logic [63:0]           key_addr_low;
		logic [15:0]           key_port;
		logic [VALUE_BITS-1:0] value_in;
	} req_t;

	typedef struct packed {
		logic                  hit;
		logic [VALUE_BITS-1:0] value_out;
		logic                  evicted_valid;
		logic [VALUE_BITS-1:0] evicted_value;
		logic [CNT_W-1:0]      live_count;
	} rsp_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DECIDE,
		ST_VDAT,
		ST_UL_RD,
		ST_UL_WR,
		ST_ALLOC,
		ST_AP1,
		ST_AP2,
		ST_DONE
	} st_t;

endpackage

// ----- hw/rtl/lkt_ram.sv -----
// generic simple dual port ram with registered read
module lkt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- hw/rtl/lru_keyed_table.sv -----
// lru keyed table top level: key search, recency list and result register
// operation: a linear scan of every slot of the key ram, one slot read per cycle,
// followed by the list update steps
// throughput: one item at a time; the next item is taken while a result waits
// reset: asynchronous active low; clears live bits, list ends, count; limit = 256
module lru_keyed_table
	import lkt_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  req_t             in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output rsp_t             out_data,
	input  logic             cfg_we,
	input  logic [CNT_W-1:0] cfg_wdata
);

	st_t state_q, state_d;

	req_t                  req_q;
	logic [CNT_W-1:0]      limit_cfg_q;
	logic [CAPACITY-1:0]   live_q;
	logic [CNT_W-1:0]      scan_q;
	logic                  scan_vld_s1;
	logic [SLOT_W-1:0]     scan_idx_s1;
	logic                  found_q, ff_ok_q;
	logic [SLOT_W-1:0]     s_q, ff_q, target_q, oldest_q, newest_q;
	logic [CNT_W-1:0]      count_q;
	logic                  hit_q, evv_q, out_valid_q;
	logic [VALUE_BITS-1:0] vout_q, evval_q;
	rsp_t                  out_q;

	// ram ports
	logic [KEY_W-1:0]      key_rdata;
	logic                  key_we;
	logic [SLOT_W-1:0]     key_waddr;
	logic                  val_we;
	logic [SLOT_W-1:0]     val_waddr, val_raddr;
	logic [VALUE_BITS-1:0] val_rdata;
	logic                  old_we, new_we;
	logic [SLOT_W-1:0]     old_waddr, new_waddr, old_wdata, new_wdata;
	logic [SLOT_W-1:0]     old_rdata, new_rdata;

	logic [CNT_W-1:0]      limit;
	logic                  evict_now, free_ok, key_eq;
	logic [SLOT_W-1:0]     free_slot;

	always_comb begin
		limit = limit_cfg_q;
		if (limit_cfg_q == '0) begin
			limit = CNT_W'(1);
		end else if (limit_cfg_q > CNT_W'(CAPACITY)) begin
			limit = CNT_W'(CAPACITY);
		end
	end

	assign evict_now = (count_q != '0) && (count_q >= limit);
	assign key_eq    = key_rdata == {req_q.key_addr_high, req_q.key_addr_low, req_q.key_port};
	// lowest free slot once the evicted one is counted in
	assign free_ok   = ff_ok_q || evv_q;
	assign free_slot = (ff_ok_q && (!evv_q || ff_q < target_q)) ? ff_q : target_q;

	assign val_raddr = (req_q.kind == KIND_PUT) ? oldest_q : s_q;
	assign key_waddr = free_slot;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		key_we    = 1'b0;
		val_we    = 1'b0;
		val_waddr = s_q;
		old_we    = 1'b0;
		old_waddr = new_rdata;
		old_wdata = old_rdata;
		new_we    = 1'b0;
		new_waddr = old_rdata;
		new_wdata = new_rdata;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (scan_vld_s1 && scan_idx_s1 == SLOT_W'(CAPACITY - 1)) begin
					state_d = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				unique case (req_q.kind)
					KIND_PUT: begin
						if (found_q) begin
							val_we  = 1'b1;
							state_d = ST_UL_RD;
						end else if (evict_now) begin
							state_d = ST_VDAT;
						end else begin
							state_d = ST_ALLOC;
						end
					end
					KIND_GET, KIND_DEL: begin
						state_d = found_q ? ST_VDAT : ST_DONE;
					end
					default: begin
						state_d = ST_DONE;
					end
				endcase
			end
			ST_VDAT: begin
				state_d = ST_UL_RD;
			end
			ST_UL_RD: begin
				state_d = ST_UL_WR;
			end
			ST_UL_WR: begin
				new_we = target_q != oldest_q;
				old_we = target_q != newest_q;
				if (req_q.kind == KIND_DEL) begin
					state_d = ST_DONE;
				end else if (req_q.kind == KIND_PUT && evv_q) begin
					state_d = ST_ALLOC;
				end else begin
					state_d = ST_AP1;
				end
			end
			ST_ALLOC: begin
				if (free_ok) begin
					key_we    = 1'b1;
					val_we    = 1'b1;
					val_waddr = free_slot;
					state_d   = ST_AP1;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_AP1: begin
				new_we    = 1'b1;
				new_waddr = target_q;
				new_wdata = target_q;
				old_we    = count_q != '0;
				old_waddr = target_q;
				old_wdata = newest_q;
				state_d   = ST_AP2;
			end
			ST_AP2: begin
				new_we    = count_q != '0;
				new_waddr = newest_q;
				new_wdata = target_q;
				state_d   = ST_DONE;
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_cfg_q <= CNT_W'(CAPACITY);
			live_q      <= '0;
			oldest_q    <= '0;
			newest_q    <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
			scan_vld_s1 <= 1'b0;
		end else begin
			if (cfg_we) begin
				limit_cfg_q <= cfg_wdata;
			end
			if (out_valid_q && out_ready && state_q != ST_DONE) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					scan_vld_s1 <= 1'b0;
					if (in_valid) begin
						scan_q  <= '0;
						found_q <= 1'b0;
						ff_ok_q <= 1'b0;
						hit_q   <= 1'b0;
						evv_q   <= 1'b0;
						vout_q  <= '0;
						evval_q <= '0;
					end
				end
				ST_SCAN: begin
					scan_vld_s1 <= scan_q < CNT_W'(CAPACITY);
					scan_idx_s1 <= scan_q[SLOT_W-1:0];
					if (scan_q < CNT_W'(CAPACITY)) begin
						scan_q <= scan_q + CNT_W'(1);
					end
					if (scan_vld_s1) begin
						if (live_q[scan_idx_s1] && key_eq && !found_q) begin
							found_q <= 1'b1;
							s_q     <= scan_idx_s1;
						end
						if (!live_q[scan_idx_s1] && !ff_ok_q) begin
							ff_ok_q <= 1'b1;
							ff_q    <= scan_idx_s1;
						end
					end
				end
				ST_DECIDE: begin
					scan_vld_s1 <= 1'b0;
					unique case (req_q.kind)
						KIND_PUT: begin
							hit_q <= found_q;
							if (found_q) begin
								target_q <= s_q;
							end else if (evict_now) begin
								evv_q    <= 1'b1;
								target_q <= oldest_q;
							end
						end
						KIND_GET, KIND_DEL: begin
							hit_q    <= found_q;
							target_q <= s_q;
						end
						default: begin
						end
					endcase
				end
				ST_VDAT: begin
					if (evv_q) begin
						evval_q <= val_rdata;
					end else begin
						vout_q <= val_rdata;
					end
				end
				ST_UL_WR: begin
					if (target_q == oldest_q) begin
						oldest_q <= new_rdata;
					end
					if (target_q == newest_q) begin
						newest_q <= old_rdata;
					end
					count_q <= count_q - CNT_W'(1);
					if (req_q.kind == KIND_DEL || (req_q.kind == KIND_PUT && evv_q)) begin
						live_q[target_q] <= 1'b0;
					end
				end
				ST_ALLOC: begin
					if (free_ok) begin
						live_q[free_slot] <= 1'b1;
						target_q          <= free_slot;
					end
				end
				ST_AP2: begin
					if (count_q == '0) begin
						oldest_q <= target_q;
					end
					newest_q <= target_q;
					count_q  <= count_q + CNT_W'(1);
				end
				ST_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q         <= 1'b1;
						out_q.hit           <= hit_q;
						out_q.value_out     <= vout_q;
						out_q.evicted_valid <= evv_q;
						out_q.evicted_value <= evval_q;
						out_q.live_count    <= count_q;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// request payload holds for the whole operation
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			req_q <= in_data;
		end
	end

	assign in_ready  = state_q == ST_IDLE;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	lkt_ram #(.WIDTH(KEY_W), .DEPTH(CAPACITY)) u_key_ram (
		.clk   (clk),
		.we    (key_we),
		.waddr (key_waddr),
		.wdata ({req_q.key_addr_high, req_q.key_addr_low, req_q.key_port}),
		.raddr (scan_q[SLOT_W-1:0]),
		.rdata (key_rdata)
	);

	lkt_ram #(.WIDTH(VALUE_BITS), .DEPTH(CAPACITY)) u_val_ram (
		.clk   (clk),
		.we    (val_we),
		.waddr (val_waddr),
		.wdata (req_q.value_in),
		.raddr (val_raddr),
		.rdata (val_rdata)
	);

	lkt_ram #(.WIDTH(SLOT_W), .DEPTH(CAPACITY)) u_older_ram (
		.clk   (clk),
		.we    (old_we),
		.waddr (old_waddr),
		.wdata (old_wdata),
		.raddr (target_q),
		.rdata (old_rdata)
	);

	lkt_ram #(.WIDTH(SLOT_W), .DEPTH(CAPACITY)) u_newer_ram (
		.clk   (clk),
		.we    (new_we),
		.waddr (new_waddr),
		.wdata (new_wdata),
		.raddr (target_q),
		.rdata (new_rdata)
	);

endmodule

// ----- hw/rtl/lkt_checker.sv -----
// port level checks for the lru keyed table, bound to the top level
`include "assert_macros.svh"

module lkt_checker
	import lkt_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_ready,
	input req_t             in_data,
	input logic             out_valid,
	input logic             out_ready,
	input rsp_t             out_data,
	input logic             cfg_we,
	input logic [CNT_W-1:0] cfg_wdata
);

	// a stalled result transfer keeps its payload
	`ASSERT_CLK(a_out_hold, clk, arst_n, out_valid && !out_ready |=> out_valid && $stable(out_data))
	// no more live entries than slots
	`ASSERT_NEVER(a_count_cap, clk, arst_n, out_valid && out_data.live_count > CNT_W'(CAPACITY))
	// eviction only happens on a put that missed
	`ASSERT_CLK(a_evict_miss, clk, arst_n, out_valid && out_data.evicted_valid |-> !out_data.hit)
	// a miss never reports a value
	`ASSERT_CLK(a_miss_zero, clk, arst_n, out_valid && !out_data.hit |-> out_data.value_out == '0)

endmodule

bind lru_keyed_table lkt_checker u_lkt_checker (.*);
